>>> hw/rtl/encoder_difference_iir_controller_defines.svh
// assertion macros for the controller rtl
`ifndef ENCODER_DIFFERENCE_IIR_CONTROLLER_DEFINES_SVH
`define ENCODER_DIFFERENCE_IIR_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define EDIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edic assertion failed");

// next-cycle implication
`define EDIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edic assertion failed");

`endif

>>> hw/rtl/edic_pkg.sv
// shared types and constants of the encoder difference iir controller
package edic_pkg;

   localparam int COEF_FRAC_BITS  = 28;
   localparam int DRIVE_FRAC_BITS = 14;
   localparam int ERR_SHIFT       = COEF_FRAC_BITS - DRIVE_FRAC_BITS;
   localparam int DRV_SHIFT       = COEF_FRAC_BITS - 16;
   localparam int ANGLE_SHIFT     = 14;
   localparam int OUT_SHIFT       = 16;

   localparam int ANGLE_W = 65;
   localparam int FILT_W  = 67;

   localparam logic signed [15:0] DRIVE_HI =
      (DRIVE_FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << DRIVE_FRAC_BITS);
   localparam logic signed [15:0] DRIVE_LO = 16'(-(1 << DRIVE_FRAC_BITS));

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_LEFT_GAIN,
      REG_RIGHT_GAIN,
      REG_COEF_A1,
      REG_COEF_A2,
      REG_COEF_B0,
      REG_COEF_B1,
      REG_COEF_B2
   } csr_reg_type;

   localparam logic signed [31:0] RST_LEFT_GAIN  = -32'sd3182320;
   localparam logic signed [31:0] RST_RIGHT_GAIN = 32'sd3167380;
   localparam logic signed [31:0] RST_COEF_A1    = 32'sd476526622;
   localparam logic signed [31:0] RST_COEF_A2    = -32'sd208131431;
   localparam logic signed [31:0] RST_COEF_B0    = 32'sd53684407;
   localparam logic signed [31:0] RST_COEF_B1    = -32'sd71328669;
   localparam logic signed [31:0] RST_COEF_B2    = 32'sd17657953;

   typedef struct packed {
      logic signed [31:0] left_gain;
      logic signed [31:0] right_gain;
      logic signed [31:0] coef_a1;
      logic signed [31:0] coef_a2;
      logic signed [31:0] coef_b0;
      logic signed [31:0] coef_b1;
      logic signed [31:0] coef_b2;
   } edic_cfg_type;

   typedef enum logic [2:0] {
      TERM_LEFT,
      TERM_RIGHT,
      TERM_A1,
      TERM_A2,
      TERM_B1,
      TERM_B2,
      TERM_B0
   } term_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST_MUL = 4'd6;
   localparam logic [STEP_W-1:0] STEP_ERR      = 4'd3;
   localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd8;

   typedef struct packed {
      logic     load;
      logic     mul_en;
      term_type mul_sel;
      logic     err_set;
      logic     finish;
   } edic_ctrl_type;

endpackage

>>> hw/rtl/edic_csr.sv
// configuration register file with apb-style access
module edic_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [edic_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output edic_pkg::edic_cfg_type            cfg
);

   edic_pkg::edic_cfg_type cfg_ff;
   edic_pkg::edic_cfg_type cfg_in;
   edic_pkg::csr_reg_type  reg_idx;
   logic                   wr_en;

   assign reg_idx    = edic_pkg::csr_reg_type'(csr_paddr[edic_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            edic_pkg::REG_LEFT_GAIN:  cfg_in.left_gain  = csr_pwdata;
            edic_pkg::REG_RIGHT_GAIN: cfg_in.right_gain = csr_pwdata;
            edic_pkg::REG_COEF_A1:    cfg_in.coef_a1    = csr_pwdata;
            edic_pkg::REG_COEF_A2:    cfg_in.coef_a2    = csr_pwdata;
            edic_pkg::REG_COEF_B0:    cfg_in.coef_b0    = csr_pwdata;
            edic_pkg::REG_COEF_B1:    cfg_in.coef_b1    = csr_pwdata;
            edic_pkg::REG_COEF_B2:    cfg_in.coef_b2    = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         edic_pkg::REG_LEFT_GAIN:  csr_prdata = cfg_ff.left_gain;
         edic_pkg::REG_RIGHT_GAIN: csr_prdata = cfg_ff.right_gain;
         edic_pkg::REG_COEF_A1:    csr_prdata = cfg_ff.coef_a1;
         edic_pkg::REG_COEF_A2:    csr_prdata = cfg_ff.coef_a2;
         edic_pkg::REG_COEF_B0:    csr_prdata = cfg_ff.coef_b0;
         edic_pkg::REG_COEF_B1:    csr_prdata = cfg_ff.coef_b1;
         edic_pkg::REG_COEF_B2:    csr_prdata = cfg_ff.coef_b2;
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_gain  <= edic_pkg::RST_LEFT_GAIN;
         cfg_ff.right_gain <= edic_pkg::RST_RIGHT_GAIN;
         cfg_ff.coef_a1    <= edic_pkg::RST_COEF_A1;
         cfg_ff.coef_a2    <= edic_pkg::RST_COEF_A2;
         cfg_ff.coef_b0    <= edic_pkg::RST_COEF_B0;
         cfg_ff.coef_b1    <= edic_pkg::RST_COEF_B1;
         cfg_ff.coef_b2    <= edic_pkg::RST_COEF_B2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/edic_dp.sv
// datapath: shared multiplier, angle and filter accumulators, history
module edic_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  edic_pkg::edic_ctrl_type       ctrl,
   input  edic_pkg::edic_cfg_type        cfg,
   input  logic signed [31:0]            left_count,
   input  logic signed [31:0]            right_count,
   output logic signed [15:0]            drive,
   output logic signed [31:0]            angle_difference
);

   localparam int AW = edic_pkg::ANGLE_W;
   localparam int FW = edic_pkg::FILT_W;
   localparam logic signed [AW-1:0] ANGLE_HALF = AW'(1) << (edic_pkg::ANGLE_SHIFT - 1);
   localparam logic signed [FW-1:0] FILT_HALF  = FW'(1) << (edic_pkg::OUT_SHIFT - 1);
   localparam logic signed [FW-1:0] HI_EXT     = FW'(edic_pkg::DRIVE_HI);
   localparam logic signed [FW-1:0] LO_EXT     = FW'(edic_pkg::DRIVE_LO);

   logic signed [31:0]    lc_ff, lc_in, rc_ff, rc_in;
   logic signed [31:0]    op_a, op_b;
   logic signed [63:0]    prod_ff, prod_in;
   edic_pkg::term_type    prod_sel_ff, prod_sel_in;
   logic                  prod_vld_ff, prod_vld_in;
   logic signed [AW-1:0]  angle_acc_ff, angle_acc_in;
   logic signed [FW-1:0]  filt_acc_ff, filt_acc_in;
   logic signed [31:0]    err_ff, err_in;
   logic signed [15:0]    drv_p1_ff, drv_p1_in, drv_p2_ff, drv_p2_in;
   logic signed [31:0]    err_p1_ff, err_p1_in, err_p2_ff, err_p2_in;
   logic signed [15:0]    out_drive_ff, out_drive_in;
   logic signed [31:0]    out_angle_ff, out_angle_in;

   logic signed [AW-1:0]  prod_angle;
   logic signed [63:0]    term_drv, term_err;
   logic signed [AW-1:0]  angle_rnd;
   logic signed [FW-1:0]  filt_rnd;
   logic signed [15:0]    drive_sat;
   logic                  angle_fits;

   always_comb begin
      case (ctrl.mul_sel)
         edic_pkg::TERM_LEFT: begin
            op_a = cfg.left_gain;
            op_b = lc_ff;
         end
         edic_pkg::TERM_RIGHT: begin
            op_a = cfg.right_gain;
            op_b = rc_ff;
         end
         edic_pkg::TERM_A1: begin
            op_a = cfg.coef_a1;
            op_b = 32'(drv_p1_ff);
         end
         edic_pkg::TERM_A2: begin
            op_a = cfg.coef_a2;
            op_b = 32'(drv_p2_ff);
         end
         edic_pkg::TERM_B1: begin
            op_a = cfg.coef_b1;
            op_b = err_p1_ff;
         end
         edic_pkg::TERM_B2: begin
            op_a = cfg.coef_b2;
            op_b = err_p2_ff;
         end
         edic_pkg::TERM_B0: begin
            op_a = cfg.coef_b0;
            op_b = err_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in     = op_a * op_b;
   assign prod_sel_in = ctrl.mul_en ? ctrl.mul_sel : prod_sel_ff;
   assign prod_vld_in = ctrl.mul_en;

   assign prod_angle = AW'(prod_ff);
   assign term_drv   = prod_ff >>> edic_pkg::DRV_SHIFT;
   assign term_err   = prod_ff >>> edic_pkg::ERR_SHIFT;

   always_comb begin
      angle_acc_in = angle_acc_ff;
      filt_acc_in  = filt_acc_ff;
      if (ctrl.load) begin
         angle_acc_in = '0;
         filt_acc_in  = '0;
      end else if (prod_vld_ff) begin
         case (prod_sel_ff)
            edic_pkg::TERM_LEFT:  angle_acc_in = angle_acc_ff + prod_angle;
            edic_pkg::TERM_RIGHT: angle_acc_in = angle_acc_ff - prod_angle;
            edic_pkg::TERM_A1,
            edic_pkg::TERM_A2:    filt_acc_in  = filt_acc_ff + FW'(term_drv);
            edic_pkg::TERM_B1,
            edic_pkg::TERM_B2,
            edic_pkg::TERM_B0:    filt_acc_in  = filt_acc_ff + FW'(term_err);
            default: begin
            end
         endcase
      end
   end

   // round to q15.16 and saturate to 32 bits
   assign angle_rnd  = (angle_acc_ff + ANGLE_HALF) >>> edic_pkg::ANGLE_SHIFT;
   assign angle_fits = (&angle_rnd[AW-1:31]) | ~(|angle_rnd[AW-1:31]);

   always_comb begin
      if (angle_fits) begin
         err_in = angle_rnd[31:0];
      end else if (angle_rnd[AW-1]) begin
         err_in = 32'sh8000_0000;
      end else begin
         err_in = 32'sh7fff_ffff;
      end
      if (!ctrl.err_set) begin
         err_in = err_ff;
      end
   end

   // round filter sum to drive and clamp
   assign filt_rnd = (filt_acc_ff + FILT_HALF) >>> edic_pkg::OUT_SHIFT;

   always_comb begin
      if (filt_rnd > HI_EXT) begin
         drive_sat = edic_pkg::DRIVE_HI;
      end else if (filt_rnd < LO_EXT) begin
         drive_sat = edic_pkg::DRIVE_LO;
      end else begin
         drive_sat = filt_rnd[15:0];
      end
   end

   always_comb begin
      lc_in        = ctrl.load ? left_count  : lc_ff;
      rc_in        = ctrl.load ? right_count : rc_ff;
      drv_p1_in    = drv_p1_ff;
      drv_p2_in    = drv_p2_ff;
      err_p1_in    = err_p1_ff;
      err_p2_in    = err_p2_ff;
      out_drive_in = out_drive_ff;
      out_angle_in = out_angle_ff;
      if (ctrl.finish) begin
         drv_p1_in    = drive_sat;
         drv_p2_in    = drv_p1_ff;
         err_p1_in    = err_ff;
         err_p2_in    = err_p1_ff;
         out_drive_in = drive_sat;
         out_angle_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      lc_ff        <= lc_in;
      rc_ff        <= rc_in;
      prod_ff      <= prod_in;
      prod_sel_ff  <= prod_sel_in;
      angle_acc_ff <= angle_acc_in;
      filt_acc_ff  <= filt_acc_in;
      err_ff       <= err_in;
      out_drive_ff <= out_drive_in;
      out_angle_ff <= out_angle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         drv_p1_ff   <= '0;
         drv_p2_ff   <= '0;
         err_p1_ff   <= '0;
         err_p2_ff   <= '0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         drv_p1_ff   <= drv_p1_in;
         drv_p2_ff   <= drv_p2_in;
         err_p1_ff   <= err_p1_in;
         err_p2_ff   <= err_p2_in;
      end
   end

   assign drive            = out_drive_ff;
   assign angle_difference = out_angle_ff;

endmodule

>>> hw/rtl/edic_seq.sv
// sequencer stepping the shared multiplier through one control tick
`include "encoder_difference_iir_controller_defines.svh"

module edic_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output edic_pkg::edic_ctrl_type  ctrl
);

   edic_pkg::state_type               state_ff, state_in;
   logic [edic_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_free;
   logic                              running;
   logic                              at_finish;

   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign running   = (state_ff == edic_pkg::ST_RUN);
   assign at_finish = running & (step_ff == edic_pkg::STEP_FINISH);

   always_comb begin
      case (state_ff)
         edic_pkg::ST_IDLE: begin
            state_in = req_tvalid ? edic_pkg::ST_RUN : edic_pkg::ST_IDLE;
         end
         edic_pkg::ST_RUN: begin
            if ((step_ff == edic_pkg::STEP_FINISH) && out_free) begin
               state_in = edic_pkg::ST_IDLE;
            end else begin
               state_in = edic_pkg::ST_RUN;
            end
         end
         default: state_in = edic_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == edic_pkg::ST_IDLE);
      ctrl.load    = req_tready & req_tvalid;
      ctrl.mul_en  = running & (step_ff <= edic_pkg::STEP_LAST_MUL);
      ctrl.mul_sel = edic_pkg::term_type'(step_ff[2:0]);
      ctrl.err_set = running & (step_ff == edic_pkg::STEP_ERR);
      ctrl.finish  = running & (step_ff == edic_pkg::STEP_FINISH) & out_free;
      rsp_tvalid   = rsp_valid_ff;
   end

   always_comb begin
      step_in = step_ff;
      if (ctrl.load) begin
         step_in = '0;
      end else if (running && (step_ff != edic_pkg::STEP_FINISH)) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edic_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `EDIC_ASSERT_NEXT(a_load_starts, clock, reset, ctrl.load, running && (step_ff == '0))
   `EDIC_ASSERT_NEXT(a_finish_shows, clock, reset, ctrl.finish, rsp_valid_ff)
   `EDIC_ASSERT_NEXT(a_stall_holds, clock, reset, at_finish && !out_free, at_finish)

endmodule

>>> hw/rtl/encoder_difference_iir_controller.sv
// Encoder difference controller: each request carries the left and right encoder counts of one
// control tick and yields one response with the clamped drive (Q1.14) and the saturated angle
// difference (Q15.16). A single 32x32 multiplier is shared by the two gain products and the five
// filter taps, one product a cycle under a small sequencer. A request is accepted in idle and
// its response is registered at the finish step; a new one waits for idle. The user must
// write coefficient and gain registers over the csr port only while no request is in flight;
// the block does not enforce it. A response not yet taken holds the block in its last step.
module encoder_difference_iir_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,   // left_count in [31:0], right_count in [63:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,   // drive in [15:0], angle_difference in [47:16]
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [edic_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   edic_pkg::edic_cfg_type   cfg;
   edic_pkg::edic_ctrl_type  ctrl;
   logic signed [15:0]       drive;
   logic signed [31:0]       angle_difference;

   edic_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   edic_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   edic_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .cfg              (cfg),
      .left_count       ($signed(req_tdata[31:0])),
      .right_count      ($signed(req_tdata[63:32])),
      .drive            (drive),
      .angle_difference (angle_difference)
   );

   assign rsp_tdata = {angle_difference, drive};

endmodule
